FILE: rtl/fll_pkg.sv
// ----------------------------------------------------------------------------
// fll_pkg
// Shared types and constants of the floating-point literal lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package fll_pkg;

    localparam int MAX_TOKEN_LENGTH = 255;
    // longest literal that may be accepted, capped by the 8-bit length field
    localparam logic [8:0] LIMIT_LEN =
        9'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);

    localparam logic [20:0] CH_0      = 21'h30;
    localparam logic [20:0] CH_1      = 21'h31;
    localparam logic [20:0] CH_2      = 21'h32;
    localparam logic [20:0] CH_3      = 21'h33;
    localparam logic [20:0] CH_4      = 21'h34;
    localparam logic [20:0] CH_6      = 21'h36;
    localparam logic [20:0] CH_9      = 21'h39;
    localparam logic [20:0] CH_US     = 21'h5f;
    localparam logic [20:0] CH_DOT    = 21'h2e;
    localparam logic [20:0] CH_PLUS   = 21'h2b;
    localparam logic [20:0] CH_MINUS  = 21'h2d;
    localparam logic [20:0] CH_LO_A   = 21'h61;
    localparam logic [20:0] CH_LO_E   = 21'h65;
    localparam logic [20:0] CH_LO_F   = 21'h66;
    localparam logic [20:0] CH_LO_P   = 21'h70;
    localparam logic [20:0] CH_LO_X   = 21'h78;
    localparam logic [20:0] CH_UP_A   = 21'h41;
    localparam logic [20:0] CH_UP_F   = 21'h46;
    localparam logic [20:0] CH_UP_X   = 21'h58;

    typedef enum logic [1:0] {
        SIZE_DEFAULT = 2'd0,
        SIZE_F32     = 2'd1,
        SIZE_F64     = 2'd2
    } size_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_DOT_END = 2'd1,
        ERR_NO_HEX  = 2'd2,
        ERR_EXP     = 2'd3
    } err_t;

    typedef struct packed {
        logic is_dig;
        logic is_nz;
        logic is_zero;
        logic is_us;
        logic is_hexl;
        logic is_dot;
        logic is_sign;
        logic is_e;
        logic is_p;
        logic is_f;
        logic is_x;
        logic is_2;
        logic is_3;
        logic is_4;
        logic is_6;
    } cls_t;

    typedef struct packed {
        err_t        error_kind;
        logic        possible_error;
        logic        hex_form;
        size_t       size_tag;
        logic [7:0]  token_length;
        logic        accepted;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/fll_class.sv
// ----------------------------------------------------------------------------
// fll_class
// Sorts one code point into the character classes the scanner looks at.
// ----------------------------------------------------------------------------
`default_nettype none

module fll_class
    import fll_pkg::*;
(
    input  wire logic [20:0] code_point,
    output cls_t             cls
);

    always_comb
    begin
        cls.is_dig  = (code_point >= CH_0) && (code_point <= CH_9);
        cls.is_nz   = (code_point >= CH_1) && (code_point <= CH_9);
        cls.is_zero = (code_point == CH_0);
        cls.is_us   = (code_point == CH_US);
        cls.is_hexl = ((code_point >= CH_LO_A) && (code_point <= CH_LO_F)) ||
                      ((code_point >= CH_UP_A) && (code_point <= CH_UP_F));
        cls.is_dot  = (code_point == CH_DOT);
        cls.is_sign = (code_point == CH_PLUS) || (code_point == CH_MINUS);
        cls.is_e    = (code_point == CH_LO_E);
        cls.is_p    = (code_point == CH_LO_P);
        cls.is_f    = (code_point == CH_LO_F);
        cls.is_x    = (code_point == CH_LO_X) || (code_point == CH_UP_X);
        cls.is_2    = (code_point == CH_2);
        cls.is_3    = (code_point == CH_3);
        cls.is_4    = (code_point == CH_4);
        cls.is_6    = (code_point == CH_6);
    end

endmodule

`default_nettype wire

FILE: rtl/fll_fsm.sv
// ----------------------------------------------------------------------------
// fll_fsm
// Scan state machine: one transition per character, flags the deciding step.
// ----------------------------------------------------------------------------
`default_nettype none

module fll_fsm
    import fll_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire cls_t cls,
    input  wire logic start_new,
    input  wire logic at_end,
    output logic      emit,
    output res_t      res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ZERO, PH_INT, PH_DOTA, PH_FRAC, PH_LDOT, PH_EXPE, PH_ESIGN,
        PH_EDIG, PH_HEXX, PH_HDIG, PH_PEXP, PH_PSIGN, PH_PDIG, PH_SUF, PH_START
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [7:0]  chars_reg, n;
    logic [8:0]  n_inc;
    logic        hex_reg, hex_cur, hex_next;
    size_t       tag_reg, tag_cur, tag_next;
    logic        active, fin, ok, len_ok;
    logic [8:0]  len;
    size_t       rtag;
    err_t        err;

    assign active = start_new || (phase_reg != PH_IDLE);

    always_comb
    begin
        cur_phase  = start_new ? PH_START : phase_reg;
        n          = start_new ? 8'd0 : chars_reg;
        hex_cur    = start_new ? 1'b0 : hex_reg;
        tag_cur    = start_new ? SIZE_DEFAULT : tag_reg;
        n_inc      = {1'b0, n} + 9'd1;
        phase_next = cur_phase;
        hex_next   = hex_cur;
        tag_next   = tag_cur;
        fin        = 1'b0;
        ok         = 1'b0;
        len        = {1'b0, n};
        rtag       = SIZE_DEFAULT;
        err        = ERR_NONE;

        if (at_end)
        begin
            fin = 1'b1;
            case (cur_phase)
                PH_DOTA: err = ERR_DOT_END;
                PH_FRAC, PH_EDIG, PH_PDIG: ok = 1'b1;
                PH_EXPE, PH_ESIGN, PH_PEXP, PH_PSIGN: err = ERR_EXP;
                PH_SUF:
                begin
                    ok  = 1'b1;
                    len = (tag_cur != SIZE_DEFAULT) ? {1'b0, n} - 9'd1 : {1'b0, n};
                end
                default: ok = 1'b0;
            endcase
        end
        else
        begin
            case (cur_phase)
                PH_START:
                begin
                    if (cls.is_nz)        phase_next = PH_INT;
                    else if (cls.is_zero) phase_next = PH_ZERO;
                    else if (cls.is_dot)  phase_next = PH_LDOT;
                    else                  fin = 1'b1;
                end
                PH_ZERO:
                begin
                    if (cls.is_dot) phase_next = PH_DOTA;
                    else if (cls.is_x)
                    begin
                        hex_next   = 1'b1;
                        phase_next = PH_HEXX;
                    end
                    else fin = 1'b1;
                end
                PH_INT:
                begin
                    if (cls.is_dig || cls.is_us) phase_next = PH_INT;
                    else if (cls.is_dot)         phase_next = PH_DOTA;
                    else if (cls.is_e)           phase_next = PH_EXPE;
                    else if (cls.is_f)
                    begin
                        tag_next   = SIZE_DEFAULT;
                        phase_next = PH_SUF;
                    end
                    else fin = 1'b1;
                end
                PH_DOTA, PH_LDOT:
                begin
                    if (cls.is_dig) phase_next = PH_FRAC;
                    else            fin = 1'b1;
                end
                PH_FRAC, PH_EDIG, PH_PDIG:
                begin
                    if (cls.is_dig || cls.is_us) phase_next = cur_phase;
                    else if (cls.is_e && (cur_phase == PH_FRAC)) phase_next = PH_EXPE;
                    else if (cls.is_f)
                    begin
                        tag_next   = SIZE_DEFAULT;
                        phase_next = PH_SUF;
                    end
                    else
                    begin
                        fin = 1'b1;
                        ok  = 1'b1;
                    end
                end
                PH_EXPE:
                begin
                    if (cls.is_sign)    phase_next = PH_ESIGN;
                    else if (cls.is_nz) phase_next = PH_EDIG;
                    else
                    begin
                        fin = 1'b1;
                        err = ERR_EXP;
                    end
                end
                PH_ESIGN:
                begin
                    if (cls.is_nz) phase_next = PH_EDIG;
                    else
                    begin
                        fin = 1'b1;
                        err = ERR_EXP;
                    end
                end
                PH_HEXX:
                begin
                    if (cls.is_dig || cls.is_hexl) phase_next = PH_HDIG;
                    else
                    begin
                        fin = 1'b1;
                        err = ERR_NO_HEX;
                    end
                end
                PH_HDIG:
                begin
                    if (cls.is_dig || cls.is_hexl || cls.is_us) phase_next = PH_HDIG;
                    else if (cls.is_p)                          phase_next = PH_PEXP;
                    else                                        fin = 1'b1;
                end
                PH_PEXP:
                begin
                    if (cls.is_sign)     phase_next = PH_PSIGN;
                    else if (cls.is_dig) phase_next = PH_PDIG;
                    else
                    begin
                        fin = 1'b1;
                        err = ERR_EXP;
                    end
                end
                PH_PSIGN:
                begin
                    if (cls.is_dig) phase_next = PH_PDIG;
                    else
                    begin
                        fin = 1'b1;
                        err = ERR_EXP;
                    end
                end
                PH_SUF:
                begin
                    ok = 1'b1;
                    if (tag_cur == SIZE_DEFAULT)
                    begin
                        if (cls.is_3)      tag_next = SIZE_F32;
                        else if (cls.is_6) tag_next = SIZE_F64;
                        else               fin = 1'b1;
                    end
                    else if (((tag_cur == SIZE_F32) && cls.is_2) ||
                             ((tag_cur == SIZE_F64) && cls.is_4))
                    begin
                        fin  = 1'b1;
                        len  = n_inc;
                        rtag = tag_cur;
                    end
                    else
                    begin
                        // f3 or f6 without its second digit: only the f counts
                        fin = 1'b1;
                        len = {1'b0, n} - 9'd1;
                    end
                end
                default: fin = 1'b1;
            endcase

            // overlong attempt: a non-deciding step that runs past the limit
            if (!fin && (n_inc > LIMIT_LEN))
            begin
                fin = 1'b1;
                ok  = 1'b0;
                err = ERR_NONE;
            end
        end

        len_ok             = ok && (len <= LIMIT_LEN);
        emit               = step && active && fin;
        res.accepted       = len_ok;
        res.token_length   = len_ok ? len[7:0] : 8'd0;
        res.size_tag       = len_ok ? rtag : SIZE_DEFAULT;
        res.hex_form       = hex_next;
        res.possible_error = !len_ok && (err != ERR_NONE);
        res.error_kind     = len_ok ? ERR_NONE : err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            chars_reg <= 8'd0;
            hex_reg   <= 1'b0;
            tag_reg   <= SIZE_DEFAULT;
        end
        else if (step && active)
        begin
            hex_reg <= hex_next;
            tag_reg <= tag_next;
            if (fin)
            begin
                phase_reg <= PH_IDLE;
            end
            else
            begin
                phase_reg <= phase_next;
                chars_reg <= n_inc[7:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/float_literal_lexer.sv
// ----------------------------------------------------------------------------
// float_literal_lexer
// Recognizes floating-point literals in a stream of code points.
// ----------------------------------------------------------------------------
// One character is taken per clock. Each accepted transaction is held in an
// input register, then stepped through the scan state machine, and a deciding
// step lands its result in the output register. The input side keeps taking a
// character every cycle and stalls only while a finished result waits in the
// output register with m_tready low. Most characters produce no result; at most
// one result comes per scan attempt.
`default_nettype none

module float_literal_lexer
    import fll_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic [1:0]  s_tuser,   // [0] start_new, [1] at_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [0] accepted, [8:1] token_length,
                                        // [10:9] size_tag, [11] hex_form,
                                        // [12] possible_error,
                                        // [14:13] error_kind, [15] zero
);

    logic        in_valid_reg;
    logic [20:0] cp_reg;
    logic        start_reg, end_reg;
    logic        out_valid_reg;
    res_t        res_reg;
    logic        advance, step, emit;
    cls_t        cls;
    res_t        res;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    fll_class u_class (
        .code_point (cp_reg),
        .cls        (cls)
    );

    fll_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cls       (cls),
        .start_new (start_reg),
        .at_end    (end_reg),
        .emit      (emit),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= step && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cp_reg    <= s_tdata[20:0];
            start_reg <= s_tuser[0];
            end_reg   <= s_tuser[1];
        end
        if (advance && emit)
        begin
            res_reg <= res;
        end
    end

    logic [2:0] unused_pad;
    assign unused_pad = s_tdata[23:21];

    // an accepted literal never carries an error code
    a_accept_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[14:13] == ERR_NONE) && !m_tdata[12])
        else $error("accepted result carries an error");

    // the error hint follows the error code
    a_hint_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[12] == (m_tdata[14:13] != ERR_NONE)))
        else $error("possible_error does not match error_kind");

    // an accepted literal has a non-zero length, a rejected one has none
    a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[8:1] != 8'd0)))
        else $error("token_length inconsistent with accepted");

    // a transaction taken in always sits in the input register next cycle
    a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("input transaction lost");

    // a result that was not taken stays in the output register
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(res_reg))
        else $error("pending result dropped");

endmodule

`default_nettype wire
